FILE: src/mfr_pkg.sv
// ============================================================================
// mfr_pkg
// Shared codes and types for the RGB median filter.
// ============================================================================
`default_nettype none

package mfr_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_IMAGE_WIDTH   = 2'd0,
        CFG_IMAGE_HEIGHT  = 2'd1,
        CFG_WINDOW_RADIUS = 2'd2,
        CFG_BORDER_MODE   = 2'd3
    } cfg_index_t;

    // border handling codes
    localparam logic [1:0] MODE_ZERO   = 2'd0;
    localparam logic [1:0] MODE_MIRROR = 2'd1;
    localparam logic [1:0] MODE_ADJUST = 2'd2;

    // request codes
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    // register reset values
    localparam logic [10:0] RST_WIDTH  = 11'd640;
    localparam logic [15:0] RST_HEIGHT = 16'd480;
    localparam logic [1:0]  RST_RADIUS = 2'd2;
    localparam logic [1:0]  RST_MODE   = MODE_ZERO;

    localparam int CFG_DW = 16;
    localparam int PIX_W  = 24;

    // tag carried alongside a window on its way to the sorter
    typedef struct packed {
        logic valid;
        logic last;
    } item_tag_t;

endpackage

`default_nettype wire

FILE: src/median_filter_rgb.sv
// ============================================================================
// median_filter_rgb
// Streaming RGB median filter over a square window with line storage.
// ============================================================================
//
//  channel  handshake             payload
//  -------  --------------------  -----------------------------------------
//  in       in_valid / in_stall   req_type, pixel_c0, pixel_c1, pixel_c2
//  out      out_valid / out_stall out_c0, out_c1, out_c2, last_of_frame
//  cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
//  One item per cycle while in_stall is low; a result passes the bank read,
//  pairwise compare and rank select registers after the transfer that causes it.
//  Line storage is (2*MAX_RADIUS+1)^2 banks, one write and one read per cycle.
//  Reset clears counters and valid flags; line storage is not cleared.
//  A stalled output holds its stage; earlier stages keep filling bubbles.
//
`default_nettype none

module median_filter_rgb
    import mfr_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 2
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              req_type,
    input  wire logic [7:0]        pixel_c0,
    input  wire logic [7:0]        pixel_c1,
    input  wire logic [7:0]        pixel_c2,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic      [7:0]        out_c0,
    output logic      [7:0]        out_c1,
    output logic      [7:0]        out_c2,
    output logic                   last_of_frame,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire cfg_index_t        cfg_index,
    input  wire logic [CFG_DW-1:0] cfg_data
);

    localparam int LR = 2 * MAX_RADIUS + 1;
    localparam int SW = $clog2(LR);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int AW = $clog2((MAX_WIDTH + LR - 1) / LR);

    logic [10:0] width_reg;
    logic [15:0] height_reg;
    logic [1:0]  radius_reg;
    logic [1:0]  mode_reg;

    logic [WW-1:0] w_eff;
    logic [15:0]   h_eff;
    logic [1:0]    r_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            radius_reg <= RST_RADIUS;
            mode_reg   <= RST_MODE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:   width_reg  <= cfg_data[10:0];
                CFG_IMAGE_HEIGHT:  height_reg <= cfg_data[15:0];
                CFG_WINDOW_RADIUS: radius_reg <= cfg_data[1:0];
                CFG_BORDER_MODE:   mode_reg   <= cfg_data[1:0];
                default:           mode_reg   <= mode_reg;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(width_reg);
        end
        h_eff = (height_reg == '0) ? 16'd1 : height_reg;
        r_eff = (32'(radius_reg) > MAX_RADIUS) ? 2'(MAX_RADIUS) : radius_reg;
    end

    // pipeline advance, output side first
    logic s1_valid, s2_valid, ov;
    logic en1, en2, en_out, acc;

    assign en_out   = !ov || !out_stall;
    assign en2      = !s2_valid || en_out;
    assign en1      = !s1_valid || en2;
    assign in_stall = !en1;
    assign acc      = in_valid && en1;

    logic             wr_en;
    logic [SW-1:0]    wr_slot, wr_res;
    logic [AW-1:0]    wr_addr;
    logic [PIX_W-1:0] wr_data;
    logic [AW-1:0]    rd_addr [LR];
    item_tag_t        s1_tag;
    logic [SW-1:0]    s1_col_sel [LR];
    logic [SW-1:0]    s1_row_sel [LR];
    logic [LR*LR-1:0] s1_win_valid, s1_win_zero;
    logic [PIX_W-1:0] bank_data [LR][LR];

    assign s1_valid = s1_tag.valid;

    mfr_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS),
        .LR         (LR),
        .SW         (SW),
        .WW         (WW),
        .AW         (AW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .w_eff        (w_eff),
        .h_eff        (h_eff),
        .r_eff        (r_eff),
        .mode         (mode_reg),
        .acc          (acc),
        .req_type     (req_type),
        .pixel        ({pixel_c2, pixel_c1, pixel_c0}),
        .en1          (en1),
        .wr_en        (wr_en),
        .wr_slot      (wr_slot),
        .wr_res       (wr_res),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_addr      (rd_addr),
        .s1_tag       (s1_tag),
        .s1_col_sel   (s1_col_sel),
        .s1_row_sel   (s1_row_sel),
        .s1_win_valid (s1_win_valid),
        .s1_win_zero  (s1_win_zero)
    );

    // bank [slot][column mod LR]
    genvar s, m;
    generate
        for (s = 0; s < LR; s++)
        begin : g_slot
            for (m = 0; m < LR; m++)
            begin : g_res
                mfr_line_bank #(
                    .AW (AW)
                ) u_bank (
                    .clk   (clk),
                    .we    (wr_en && (wr_slot == SW'(s)) && (wr_res == SW'(m))),
                    .waddr (wr_addr),
                    .wdata (wr_data),
                    .re    (en1),
                    .raddr (rd_addr[m]),
                    .rdata (bank_data[s][m])
                );
            end
        end
    endgenerate

    mfr_median #(
        .MAX_RADIUS (MAX_RADIUS),
        .LR         (LR),
        .SW         (SW)
    ) u_median (
        .clk          (clk),
        .rst_n        (rst_n),
        .en2          (en2),
        .en_out       (en_out),
        .s1_tag       (s1_tag),
        .s1_col_sel   (s1_col_sel),
        .s1_row_sel   (s1_row_sel),
        .s1_win_valid (s1_win_valid),
        .s1_win_zero  (s1_win_zero),
        .bank_data    (bank_data),
        .s2_valid     (s2_valid),
        .out_valid    (ov),
        .out_c0       (out_c0),
        .out_c1       (out_c1),
        .out_c2       (out_c2),
        .out_last     (last_of_frame)
    );

    assign out_valid = ov;

endmodule

`default_nettype wire

FILE: src/mfr_line_bank.sv
// ============================================================================
// mfr_line_bank
// One bank of line storage: one write port, one registered read port with
// write-to-read forwarding.
// ============================================================================
`default_nettype none

module mfr_line_bank
    import mfr_pkg::*;
#(
    parameter int AW = 8
)
(
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [PIX_W-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [PIX_W-1:0] rdata
);

    logic [PIX_W-1:0] mem [2**AW];
    logic [PIX_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            // same-cycle write wins
            if (we && (waddr == raddr))
            begin
                rdata_reg <= wdata;
            end
            else
            begin
                rdata_reg <= mem[raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: src/mfr_ctrl.sv
// ============================================================================
// mfr_ctrl
// Stream position counters, line write addressing, window read addressing
// and border decode for each emitted pixel.
// ============================================================================
`default_nettype none

module mfr_ctrl
    import mfr_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 2,
    parameter int LR         = 2 * MAX_RADIUS + 1,
    parameter int SW         = $clog2(LR),
    parameter int WW         = $clog2(MAX_WIDTH + 1),
    parameter int AW         = $clog2((MAX_WIDTH + LR - 1) / LR)
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [WW-1:0]    w_eff,
    input  wire logic [15:0]      h_eff,
    input  wire logic [1:0]       r_eff,
    input  wire logic [1:0]       mode,
    input  wire logic             acc,
    input  wire logic             req_type,
    input  wire logic [PIX_W-1:0] pixel,
    input  wire logic             en1,
    output logic                  wr_en,
    output logic      [SW-1:0]    wr_slot,
    output logic      [SW-1:0]    wr_res,
    output logic      [AW-1:0]    wr_addr,
    output logic      [PIX_W-1:0] wr_data,
    output logic      [AW-1:0]    rd_addr [LR],
    output item_tag_t             s1_tag,
    output logic      [SW-1:0]    s1_col_sel [LR],
    output logic      [SW-1:0]    s1_row_sel [LR],
    output logic [LR*LR-1:0]      s1_win_valid,
    output logic [LR*LR-1:0]      s1_win_zero
);

    localparam int NWIN = LR * LR;
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int CS   = WW + 2;
    localparam int RS   = 18;
    localparam int PW   = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 2);
    localparam int RSH  = WW + 3;
    localparam int RK   = ((1 << RSH) + LR - 1) / LR;
    localparam int KW   = $clog2(RK + 1);

    // stream position
    logic [CW-1:0] in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [AW-1:0] in_q_reg, in_q_next, out_q_reg, out_q_next;
    logic [SW-1:0] in_r_reg, in_r_next, out_r_reg, out_r_next;
    logic [SW-1:0] in_slot_reg, in_slot_next, out_slot_reg, out_slot_next;
    logic [15:0]   out_row_reg, out_row_next;
    logic [PW-1:0] pending_reg, pending_next;

    // stage 1 window control
    item_tag_t     tag_reg, tag_next;
    logic [SW-1:0] col_sel_reg [LR];
    logic [SW-1:0] col_sel_next [LR];
    logic [SW-1:0] row_sel_reg [LR];
    logic [SW-1:0] row_sel_next [LR];
    logic [NWIN-1:0] win_valid_reg, win_valid_next, win_zero_reg, win_zero_next;

    logic          is_pixel, emit;
    logic [PW-1:0] lag;

    assign is_pixel = (req_type == REQ_PIXEL);
    assign lag      = PW'(r_eff) * PW'(w_eff) + PW'(r_eff);
    assign emit     = is_pixel ? ((PW'(pending_reg) + 1'b1) > lag) : (pending_reg != '0);

    assign wr_en   = acc && is_pixel;
    assign wr_slot = in_slot_reg;
    assign wr_res  = in_r_reg;
    assign wr_addr = in_q_reg;
    assign wr_data = pixel;

    // counter advance
    always_comb
    begin
        in_col_next   = in_col_reg;
        in_q_next     = in_q_reg;
        in_r_next     = in_r_reg;
        in_slot_next  = in_slot_reg;
        out_col_next  = out_col_reg;
        out_q_next    = out_q_reg;
        out_r_next    = out_r_reg;
        out_slot_next = out_slot_reg;
        out_row_next  = out_row_reg;
        pending_next  = pending_reg;
        if (acc)
        begin
            if (is_pixel)
            begin
                if ((WW'(in_col_reg) + 1'b1) >= w_eff)
                begin
                    in_col_next  = '0;
                    in_q_next    = '0;
                    in_r_next    = '0;
                    in_slot_next = (in_slot_reg == SW'(LR - 1)) ? '0 : in_slot_reg + 1'b1;
                end
                else
                begin
                    in_col_next = in_col_reg + 1'b1;
                    if (in_r_reg == SW'(LR - 1))
                    begin
                        in_r_next = '0;
                        in_q_next = in_q_reg + 1'b1;
                    end
                    else
                    begin
                        in_r_next = in_r_reg + 1'b1;
                    end
                end
                if (!emit)
                begin
                    pending_next = pending_reg + 1'b1;
                end
            end
            else if (emit)
            begin
                pending_next = pending_reg - 1'b1;
            end
            if (emit)
            begin
                if ((WW'(out_col_reg) + 1'b1) >= w_eff)
                begin
                    out_col_next  = '0;
                    out_q_next    = '0;
                    out_r_next    = '0;
                    out_slot_next = (out_slot_reg == SW'(LR - 1)) ? '0 : out_slot_reg + 1'b1;
                    out_row_next  = ((17'(out_row_reg) + 1'b1) >= 17'(h_eff)) ?
                                    '0 : out_row_reg + 1'b1;
                end
                else
                begin
                    out_col_next = out_col_reg + 1'b1;
                    if (out_r_reg == SW'(LR - 1))
                    begin
                        out_r_next = '0;
                        out_q_next = out_q_reg + 1'b1;
                    end
                    else
                    begin
                        out_r_next = out_r_reg + 1'b1;
                    end
                end
            end
        end
    end

    // window decode
    logic signed [CS-1:0] jj, wm1, bcol, xs, xx, tx, kk;
    logic signed [RS-1:0] ii, hm1, ys, yy, ty, dy;
    logic signed [AW:0]   qb;
    logic [SW-1:0]        rb;
    logic signed [SW+1:0] rt, st;
    logic [SW:0]          ksum;
    logic [WW-1:0]        wm1u;
    logic [WW+KW-1:0]     prod, wq_full;
    logic [WW-1:0]        wrem;
    logic                 spec, mirror;
    logic [LR-1:0]        col_in, col_r, row_in, row_r;

    always_comb
    begin
        mirror = (mode == MODE_MIRROR);
        jj     = CS'($signed({1'b0, out_col_reg}));
        wm1u   = w_eff - 1'b1;
        wm1    = CS'($signed({1'b0, wm1u}));
        ii     = RS'($signed({1'b0, out_row_reg}));
        hm1    = RS'($signed({1'b0, h_eff})) - 1;

        // (W-1) / LR by reciprocal
        prod    = (WW + KW)'(wm1u) * (WW + KW)'(RK);
        wq_full = prod >> RSH;
        wrem    = wm1u - WW'(wq_full * (WW + KW)'(LR));

        // every mirrored column collapses onto W-1 when the whole window is past it
        spec = mirror && ((jj - CS'($signed({1'b0, r_eff}))) > wm1);
        if (spec)
        begin
            bcol = wm1;
            qb   = $signed({1'b0, AW'(wq_full)});
            rb   = SW'(wrem);
        end
        else
        begin
            bcol = jj - CS'(MAX_RADIUS);
            rt   = $signed({2'b00, out_r_reg}) - (SW + 2)'(MAX_RADIUS);
            if (rt < 0)
            begin
                rb = SW'(rt + (SW + 2)'(LR));
                qb = $signed({1'b0, out_q_reg}) - 2'sd1;
            end
            else
            begin
                rb = SW'(rt);
                qb = $signed({1'b0, out_q_reg});
            end
        end
        rt = '0;

        for (int m = 0; m < LR; m++)
        begin
            rd_addr[m] = AW'(qb + (((SW + 1)'(m) < {1'b0, rb}) ? 2'sd1 : 2'sd0));
        end

        for (int xi = 0; xi < LR; xi++)
        begin
            xs = CS'(xi - MAX_RADIUS);
            xx = jj + xs;
            if (xx > wm1)
            begin
                tx = jj - xs;
            end
            else if (xx < 0)
            begin
                tx = -xx;
            end
            else
            begin
                tx = xx;
            end
            if (tx < 0)
            begin
                tx = '0;
            end
            if (tx > wm1)
            begin
                tx = wm1;
            end
            kk   = mirror ? (tx - bcol) : CS'(xi);
            ksum = {1'b0, rb} + (SW + 1)'(kk);
            if (ksum >= (SW + 1)'(LR))
            begin
                ksum = ksum - (SW + 1)'(LR);
            end
            col_sel_next[xi] = SW'(ksum);
            col_in[xi] = (xx >= 0) && (xx <= wm1);
            col_r[xi]  = (xi >= MAX_RADIUS - 32'(r_eff)) && (xi <= MAX_RADIUS + 32'(r_eff));
        end

        for (int yi = 0; yi < LR; yi++)
        begin
            ys = RS'(yi - MAX_RADIUS);
            yy = ii + ys;
            if (mirror)
            begin
                if (yy > hm1)
                begin
                    ty = ii - ys;
                end
                else if (yy < 0)
                begin
                    ty = -yy;
                end
                else
                begin
                    ty = yy;
                end
                if (ty < 0)
                begin
                    ty = '0;
                end
                if (ty > hm1)
                begin
                    ty = hm1;
                end
                dy = ty - ii;
                if (dy < -RS'(MAX_RADIUS))
                begin
                    dy = -RS'(MAX_RADIUS);
                end
                if (dy > RS'(MAX_RADIUS))
                begin
                    dy = RS'(MAX_RADIUS);
                end
            end
            else
            begin
                ty = yy;
                dy = ys;
            end
            st = $signed({2'b00, out_slot_reg}) + (SW + 2)'(dy);
            if (st < 0)
            begin
                st = st + (SW + 2)'(LR);
            end
            else if (st >= (SW + 2)'(LR))
            begin
                st = st - (SW + 2)'(LR);
            end
            row_sel_next[yi] = SW'(st);
            row_in[yi] = (yy >= 0) && (yy <= hm1);
            row_r[yi]  = (yi >= MAX_RADIUS - 32'(r_eff)) && (yi <= MAX_RADIUS + 32'(r_eff));
        end

        for (int xi = 0; xi < LR; xi++)
        begin
            for (int yi = 0; yi < LR; yi++)
            begin
                win_valid_next[xi * LR + yi] = col_r[xi] && row_r[yi] &&
                    ((mode != MODE_ADJUST) || (col_in[xi] && row_in[yi]));
                win_zero_next[xi * LR + yi] = (mode != MODE_MIRROR) &&
                    (mode != MODE_ADJUST) && !(col_in[xi] && row_in[yi]);
            end
        end

        tag_next.valid = acc && emit;
        tag_next.last  = (out_row_reg == (h_eff - 1'b1)) && (WW'(out_col_reg) == wm1u);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_q_reg     <= '0;
            in_r_reg     <= '0;
            in_slot_reg  <= '0;
            out_col_reg  <= '0;
            out_q_reg    <= '0;
            out_r_reg    <= '0;
            out_slot_reg <= '0;
            out_row_reg  <= '0;
            pending_reg  <= '0;
            tag_reg      <= '0;
        end
        else
        begin
            in_col_reg   <= in_col_next;
            in_q_reg     <= in_q_next;
            in_r_reg     <= in_r_next;
            in_slot_reg  <= in_slot_next;
            out_col_reg  <= out_col_next;
            out_q_reg    <= out_q_next;
            out_r_reg    <= out_r_next;
            out_slot_reg <= out_slot_next;
            out_row_reg  <= out_row_next;
            pending_reg  <= pending_next;
            if (en1)
            begin
                tag_reg <= tag_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            col_sel_reg   <= col_sel_next;
            row_sel_reg   <= row_sel_next;
            win_valid_reg <= win_valid_next;
            win_zero_reg  <= win_zero_next;
        end
    end

    assign s1_tag       = tag_reg;
    assign s1_col_sel   = col_sel_reg;
    assign s1_row_sel   = row_sel_reg;
    assign s1_win_valid = win_valid_reg;
    assign s1_win_zero  = win_zero_reg;

endmodule

`default_nettype wire

FILE: src/mfr_median.sv
// ============================================================================
// mfr_median
// Rank-select median of each channel: pairwise compare stage, then rank
// count and select into the output register.
// ============================================================================
`default_nettype none

module mfr_median
    import mfr_pkg::*;
#(
    parameter int MAX_RADIUS = 2,
    parameter int LR         = 2 * MAX_RADIUS + 1,
    parameter int SW         = $clog2(LR)
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en2,
    input  wire logic             en_out,
    input  wire item_tag_t        s1_tag,
    input  wire logic [SW-1:0]    s1_col_sel [LR],
    input  wire logic [SW-1:0]    s1_row_sel [LR],
    input  wire logic [LR*LR-1:0] s1_win_valid,
    input  wire logic [LR*LR-1:0] s1_win_zero,
    input  wire logic [PIX_W-1:0] bank_data [LR][LR],
    output logic                  s2_valid,
    output logic                  out_valid,
    output logic      [7:0]       out_c0,
    output logic      [7:0]       out_c1,
    output logic      [7:0]       out_c2,
    output logic                  out_last
);

    localparam int NWIN = LR * LR;
    localparam int NW   = $clog2(NWIN + 1);

    logic [PIX_W-1:0] val_next [NWIN];
    logic [PIX_W-1:0] val_reg  [NWIN];
    logic [NWIN-1:0]  lt_next  [3][NWIN];
    logic [NWIN-1:0]  lt_reg   [3][NWIN];
    logic [NWIN-1:0]  valid_reg;
    logic [NW-1:0]    half_next, half_reg;
    item_tag_t        tag2_reg;

    logic             ov_reg;
    logic             last_reg;
    logic [7:0]       med_next [3];
    logic [7:0]       med_reg  [3];

    genvar e, k, c;
    generate
        for (e = 0; e < NWIN; e++)
        begin : g_val
            assign val_next[e] = s1_win_zero[e] ? '0 :
                bank_data[s1_row_sel[e % LR]][s1_col_sel[e / LR]];
        end
        for (c = 0; c < 3; c++)
        begin : g_ch
            for (e = 0; e < NWIN; e++)
            begin : g_row
                for (k = 0; k < NWIN; k++)
                begin : g_col
                    // ties break on position so every rank is unique
                    assign lt_next[c][e][k] = s1_win_valid[k] &&
                        ((val_next[k][c*8 +: 8] < val_next[e][c*8 +: 8]) ||
                         ((val_next[k][c*8 +: 8] == val_next[e][c*8 +: 8]) && (k < e)));
                end
            end
        end
    endgenerate

    assign half_next = NW'($countones(s1_win_valid) >> 1);

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            med_next[ch] = '0;
            for (int n = 0; n < NWIN; n++)
            begin
                if (valid_reg[n] && (NW'($countones(lt_reg[ch][n])) == half_reg))
                begin
                    med_next[ch] = med_next[ch] | val_reg[n][ch*8 +: 8];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag2_reg <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (en2)
            begin
                tag2_reg <= s1_tag;
            end
            if (en_out)
            begin
                ov_reg <= tag2_reg.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            val_reg   <= val_next;
            lt_reg    <= lt_next;
            valid_reg <= s1_win_valid;
            half_reg  <= half_next;
        end
        if (en_out)
        begin
            med_reg  <= med_next;
            last_reg <= tag2_reg.last;
        end
    end

    assign s2_valid  = tag2_reg.valid;
    assign out_valid = ov_reg;
    assign out_c0    = med_reg[0];
    assign out_c1    = med_reg[1];
    assign out_c2    = med_reg[2];
    assign out_last  = last_reg;

endmodule

`default_nettype wire

FILE: tb/tb_median_filter_rgb.sv
// ----------------------------------------------------------------------------
// tb_median_filter_rgb
// Self-checking testbench for the streaming RGB median filter. Whole frames
// of random pixels are pushed through under every border mode and radius,
// each frame drained with flush requests. A scoreboard predicts every
// output pixel and compares it field by field. Both sides stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_median_filter_rgb;
    import mfr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_W    = 1024;
    localparam int LINE_ROWS = 5;
    localparam int RAD_MAX   = 2;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic       last;
    } pix_result_t;

    class median_scoreboard;
        bit [23:0]   line_mem[LINE_ROWS * LINE_W];
        bit [23:0]   win[25];
        int          in_row, in_col, out_row, out_col;
        int          in_slot, out_slot, pending;
        bit [10:0]   width_reg;
        bit [15:0]   height_reg;
        bit [1:0]    radius_reg;
        bit [1:0]    mode_reg;
        pix_result_t expected_q[$];
        int          errors;
        int          outputs_checked;
        int          pixels_in;
        int          flushes_in;

        function new();
            in_row = 0; in_col = 0; out_row = 0; out_col = 0;
            in_slot = 0; out_slot = 0; pending = 0;
            width_reg = RST_WIDTH;
            height_reg = RST_HEIGHT;
            radius_reg = RST_RADIUS;
            mode_reg = RST_MODE;
            errors = 0;
            outputs_checked = 0;
            pixels_in = 0;
            flushes_in = 0;
        endfunction

        function int eff_w();
            if (width_reg == 0) return 1;
            if (width_reg > LINE_W) return LINE_W;
            return int'(width_reg);
        endfunction

        function int eff_h();
            return (height_reg == 0) ? 1 : int'(height_reg);
        endfunction

        function int eff_r();
            return (radius_reg > RAD_MAX) ? RAD_MAX : int'(radius_reg);
        endfunction

        function int clip(int v, int lo, int hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function void write_reg(cfg_index_t idx, logic [15:0] data);
            case (idx)
                CFG_IMAGE_WIDTH:   width_reg = data[10:0];
                CFG_IMAGE_HEIGHT:  height_reg = data;
                CFG_WINDOW_RADIUS: radius_reg = data[1:0];
                CFG_BORDER_MODE:   mode_reg = data[1:0];
                default:           mode_reg = mode_reg;
            endcase
        endfunction

        function bit [23:0] line_read(int tr, int tc);
            int dy;
            int slot;
            dy = clip(tr - out_row, -RAD_MAX, RAD_MAX);
            slot = (out_slot + LINE_ROWS + dy) % LINE_ROWS;
            return line_mem[slot * LINE_W + clip(tc, 0, LINE_W - 1)];
        endfunction

        function logic [7:0] mid_rank(int n, int sh);
            byte unsigned v[25];
            byte unsigned t;
            int b;
            if (n <= 0) return 8'd0;
            for (int a = 0; a < n; a++) v[a] = win[a][sh +: 8];
            for (int a = 1; a < n; a++) begin
                t = v[a];
                b = a - 1;
                while (b >= 0 && v[b] > t) begin
                    v[b + 1] = v[b];
                    b--;
                end
                v[b + 1] = t;
            end
            return v[n / 2];
        endfunction

        function void predict_output();
            int w, h, r, n, yy, xx, ty, tx;
            bit in_img;
            pix_result_t res;
            w = eff_w(); h = eff_h(); r = eff_r();
            n = 0;
            for (int x = -r; x <= r; x++) begin
                for (int y = -r; y <= r; y++) begin
                    yy = out_row + y;
                    xx = out_col + x;
                    in_img = yy >= 0 && yy < h && xx >= 0 && xx < w;
                    if (mode_reg == MODE_MIRROR) begin
                        ty = (yy > h - 1) ? out_row - y : ((yy < 0) ? -yy : yy);
                        tx = (xx > w - 1) ? out_col - x : ((xx < 0) ? -xx : xx);
                        win[n++] = line_read(clip(ty, 0, h - 1), clip(tx, 0, w - 1));
                    end else if (mode_reg == MODE_ADJUST) begin
                        if (in_img) win[n++] = line_read(yy, xx);
                    end else begin
                        win[n++] = in_img ? line_read(yy, xx) : 24'd0;
                    end
                end
            end
            res.c0 = mid_rank(n, 0);
            res.c1 = mid_rank(n, 8);
            res.c2 = mid_rank(n, 16);
            res.last = (out_row == h - 1 && out_col == w - 1);
            expected_q.push_back(res);
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_slot = (out_slot + 1) % LINE_ROWS;
                out_row++;
                if (out_row >= h) out_row = 0;
            end
            if (pending > 0) pending--;
        endfunction

        // note one accepted input transfer
        function void note_input(logic req, logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
            int w, lag, col;
            w = eff_w();
            lag = eff_r() * w + eff_r();
            if (req == REQ_FLUSH) begin
                flushes_in++;
                if (pending > 0) predict_output();
                return;
            end
            pixels_in++;
            col = (in_col < LINE_W) ? in_col : LINE_W - 1;
            line_mem[in_slot * LINE_W + col] = {c2, c1, c0};
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_slot = (in_slot + 1) % LINE_ROWS;
                in_row++;
                if (in_row >= eff_h()) in_row = 0;
            end
            pending++;
            if (pending > lag) predict_output();
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH %s", $realtime, msg);
            errors++;
        endtask

        task check_result(pix_result_t got);
            pix_result_t want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected output %h", got));
                return;
            end
            want = expected_q.pop_front();
            outputs_checked++;
            if (got.c0 !== want.c0)
                report_mismatch($sformatf("c0 got %h want %h", got.c0, want.c0));
            if (got.c1 !== want.c1)
                report_mismatch($sformatf("c1 got %h want %h", got.c1, want.c1));
            if (got.c2 !== want.c2)
                report_mismatch($sformatf("c2 got %h want %h", got.c2, want.c2));
            if (got.last !== want.last)
                report_mismatch($sformatf("last got %b want %b", got.last, want.last));
        endtask
    endclass

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic             req_type;
    logic [7:0]       pixel_c0, pixel_c1, pixel_c2;
    logic             out_valid;
    logic             out_stall;
    logic [7:0]       out_c0, out_c1, out_c2;
    logic             last_of_frame;
    logic             cfg_valid;
    logic             cfg_ready;
    cfg_index_t       cfg_index;
    logic [CFG_DW-1:0] cfg_data;

    median_scoreboard pix_sb;
    bit   quiet;
    int   idle_cycles;
    int   stall_run;
    int   frames_run;

    median_filter_rgb DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
        .pixel_c0(pixel_c0), .pixel_c1(pixel_c1), .pixel_c2(pixel_c2),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_c0(out_c0), .out_c1(out_c1), .out_c2(out_c2),
        .last_of_frame(last_of_frame),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (quiet || p < 65) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // monitors: sample transfers on the edge at which they happen
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            pix_sb.note_input(req_type, pixel_c0, pixel_c1, pixel_c2);
        if (rst_n && out_valid && !out_stall)
            pix_sb.check_result({out_c0, out_c1, out_c2, last_of_frame});
    end

    always @(posedge clk)
    begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_run <= 0;
        end else if (stall_run > 0) begin
            stall_run <= stall_run - 1;
        end else begin
            stall_run <= pick_gap();
            out_stall <= !quiet && ($urandom_range(0, 2) == 0);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    task write_cfg(cfg_index_t idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        pix_sb.write_reg(idx, data);
    endtask

    task send_item(logic req, logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
        int gap;
        in_valid <= 1'b1;
        req_type <= req;
        pixel_c0 <= c0;
        pixel_c1 <= c1;
        pixel_c2 <= c2;
        do @(posedge clk); while (in_stall);
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // wait for all outputs, then let the pipeline settle
    task drain_wait();
        in_valid <= 1'b0;
        while (pix_sb.expected_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_sample(int style);
        case (style)
            0: return 8'($urandom_range(0, 255));
            1: return ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
            default: return 8'($urandom_range(100, 107));
        endcase
    endfunction

    // configure, stream one full frame, then drain it with flushes
    task run_frame(logic [15:0] w, logic [15:0] h, logic [15:0] r, logic [15:0] m,
                   int style, int extra_flush);
        int ew, eh, er, lag, left;
        write_cfg(CFG_IMAGE_WIDTH, w);
        write_cfg(CFG_IMAGE_HEIGHT, h);
        write_cfg(CFG_WINDOW_RADIUS, r);
        write_cfg(CFG_BORDER_MODE, m);
        ew = pix_sb.eff_w(); eh = pix_sb.eff_h(); er = pix_sb.eff_r();
        lag = er * ew + er;
        for (int k = 0; k < ew * eh; k++)
            send_item(REQ_PIXEL, pick_sample(style), pick_sample(style), pick_sample(style));
        left = (ew * eh < lag) ? ew * eh : lag;
        repeat (left + extra_flush)
            send_item(REQ_FLUSH, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
        drain_wait();
        frames_run++;
    endtask

    initial
    begin
        pix_sb = new();
        quiet = 1'b0;
        frames_run = 0;
        idle_cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = REQ_PIXEL;
        pixel_c0 = 8'd0; pixel_c1 = 8'd0; pixel_c2 = 8'd0;
        cfg_valid = 1'b0;
        cfg_index = CFG_IMAGE_WIDTH;
        cfg_data = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: tiny frames, every mode, out-of-range register values
        send_item(REQ_FLUSH, 8'hff, 8'hff, 8'hff);       // nothing pending
        drain_wait();
        run_frame(1, 1, 0, MODE_ZERO, 1, 1);
        run_frame(3, 3, 1, MODE_ZERO, 1, 0);
        run_frame(3, 3, 1, MODE_MIRROR, 0, 0);
        run_frame(3, 3, 1, MODE_ADJUST, 0, 1);
        run_frame(0, 0, 3, 3, 1, 0);                    // zero width/height, mode 3
        run_frame(5, 2, 2, MODE_MIRROR, 2, 0);

        // random frames
        while (pix_sb.pixels_in < 250) begin
            quiet = ($urandom_range(0, 5) == 0);
            run_frame(16'($urandom_range(1, 12)), 16'($urandom_range(1, 8)),
                      16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                      $urandom_range(0, 2), $urandom_range(0, 1));
        end
        quiet = 1'b0;

        // tallest frame, width register beyond the line buffer: partial, radius
        // zero, so each pixel comes straight out
        write_cfg(CFG_IMAGE_WIDTH, 16'd2047);
        write_cfg(CFG_IMAGE_HEIGHT, 16'hffff);
        write_cfg(CFG_WINDOW_RADIUS, 0);
        write_cfg(CFG_BORDER_MODE, MODE_ZERO);
        repeat (40) send_item(REQ_PIXEL, pick_sample(0), pick_sample(0), pick_sample(0));
        drain_wait();
        repeat (20) @(posedge clk);

        $display("ran %0d frames: %0d pixels and %0d flushes in, %0d outputs checked",
                 frames_run, pix_sb.pixels_in, pix_sb.flushes_in, pix_sb.outputs_checked);
        $display("mismatches: %0d, outputs still expected: %0d",
                 pix_sb.errors, pix_sb.expected_q.size());
        if (pix_sb.errors == 0 && pix_sb.expected_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
